// ===== rtl/remote_button_command_decoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// remote button command decoder - assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef REMOTE_BUTTON_COMMAND_DECODER_TOP_ASSERT_SVH
`define REMOTE_BUTTON_COMMAND_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define RBCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbcd_pkg
// types, codes and constants shared by the remote button command decoder
// ----------------------------------------------------------------------------
package rbcd_pkg;

  localparam int CNT_W  = 10;
  localparam int HELD_W = 11;
  localparam int EVT_W  = 18;
  localparam int BYTE_W = 8;
  localparam int PH_W   = 2;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;

  // item kinds
  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_TAKE  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  // packet phases
  localparam logic [PH_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PH_W-1:0] PH_CODE  = 2'd1;
  // value byte expected (phase 3 behaves the same)
  localparam logic [PH_W-1:0] PH_DATA  = 2'd2;

  // register indexes
  localparam logic REG_TAP = 1'b0;
  localparam logic REG_LED = 1'b1;

  localparam logic [CNT_W-1:0] TAP_RESET = 10'd140;
  localparam logic [CNT_W-1:0] LED_RESET = 10'd200;

  // held button bit positions
  typedef logic [3:0] hbit_t;
  localparam hbit_t H_A     = 4'd0;
  localparam hbit_t H_B     = 4'd1;
  localparam hbit_t H_ROT   = 4'd2;
  localparam hbit_t H_UP    = 4'd3;
  localparam hbit_t H_DOWN  = 4'd4;
  localparam hbit_t H_LEFT  = 4'd5;
  localparam hbit_t H_RIGHT = 4'd6;
  localparam hbit_t H_ACT1  = 4'd7;
  localparam hbit_t H_ACT2  = 4'd8;
  localparam hbit_t H_P2UP  = 4'd9;
  localparam hbit_t H_P2DN  = 4'd10;

  localparam logic [HELD_W-1:0] HM_ROT  = 11'h004;
  localparam logic [HELD_W-1:0] HM_EXT  = 11'h1F8;
  localparam logic [HELD_W-1:0] HM_P2   = 11'h600;

  // event bit positions
  typedef logic [4:0] ebit_t;
  localparam ebit_t E_MUP   = 5'd0;
  localparam ebit_t E_MDN   = 5'd1;
  localparam ebit_t E_MENT  = 5'd2;
  localparam ebit_t E_A     = 5'd3;
  localparam ebit_t E_B     = 5'd4;
  localparam ebit_t E_ROT   = 5'd5;
  localparam ebit_t E_EXIT  = 5'd6;
  localparam ebit_t E_UP    = 5'd7;
  localparam ebit_t E_DOWN  = 5'd8;
  localparam ebit_t E_LEFT  = 5'd9;
  localparam ebit_t E_RIGHT = 5'd10;
  localparam ebit_t E_ACT1  = 5'd11;
  localparam ebit_t E_ACT2  = 5'd12;
  localparam ebit_t E_DROP  = 5'd13;
  localparam ebit_t E_PAUSE = 5'd14;
  localparam ebit_t E_START = 5'd15;
  localparam ebit_t E_P2UP  = 5'd16;
  localparam ebit_t E_P2DN  = 5'd17;

  // command characters
  typedef logic [BYTE_W-1:0] chr_t;
  localparam chr_t CH_BANG  = 8'h21;
  localparam chr_t CH_QUERY = 8'h3F;
  localparam chr_t CH_0     = 8'h30;
  localparam chr_t CH_1     = 8'h31;
  localparam chr_t CH_2     = 8'h32;
  localparam chr_t CH_3     = 8'h33;
  localparam chr_t CH_4     = 8'h34;
  localparam chr_t CH_5     = 8'h35;
  localparam chr_t CH_6     = 8'h36;
  localparam chr_t CH_7     = 8'h37;
  localparam chr_t CH_8     = 8'h38;
  localparam chr_t CH_9     = 8'h39;
  localparam chr_t CH_A     = 8'h41;
  localparam chr_t CH_B     = 8'h42;
  localparam chr_t CH_D     = 8'h44;
  localparam chr_t CH_E     = 8'h45;
  localparam chr_t CH_H     = 8'h48;
  localparam chr_t CH_I     = 8'h49;
  localparam chr_t CH_K     = 8'h4B;
  localparam chr_t CH_L     = 8'h4C;
  localparam chr_t CH_P     = 8'h50;
  localparam chr_t CH_R     = 8'h52;
  localparam chr_t CH_S     = 8'h53;
  localparam chr_t CH_T     = 8'h54;
  localparam chr_t CH_U     = 8'h55;
  localparam chr_t CH_X     = 8'h58;
  localparam chr_t CH_A_LC  = 8'h61;
  localparam chr_t CH_B_LC  = 8'h62;
  localparam chr_t CH_E_LC  = 8'h65;
  localparam chr_t CH_I_LC  = 8'h69;
  localparam chr_t CH_K_LC  = 8'h6B;
  localparam chr_t CH_Q_LC  = 8'h71;
  localparam chr_t CH_R_LC  = 8'h72;
  localparam chr_t CH_S_LC  = 8'h73;
  localparam chr_t CH_T_LC  = 8'h74;
  localparam chr_t CH_W_LC  = 8'h77;
  localparam chr_t CH_X_LC  = 8'h78;
  localparam chr_t CH_Y_LC  = 8'h79;
  localparam chr_t CH_Z_LC  = 8'h7A;

  typedef struct packed {
    logic [CNT_W-1:0] tap_ticks;
    logic [CNT_W-1:0] led_hold_ticks;
  } rbcd_cfg_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [BYTE_W-1:0] rx_byte;
    logic [EVT_W-1:0]  take_mask;
  } rbcd_item_t;

  typedef struct packed {
    logic [PH_W-1:0]   phase;
    logic [BYTE_W-1:0] code;
    logic [HELD_W-1:0] held;
    logic [EVT_W-1:0]  evt;
    logic              a_pend;
    logic              b_pend;
    logic [CNT_W-1:0]  a_cnt;
    logic [CNT_W-1:0]  b_cnt;
    logic [CNT_W-1:0]  rx_cnt;
    logic [CNT_W-1:0]  vld_cnt;
  } rbcd_state_t;

  // packed from the top bit down, so held_buttons lands in the low bits
  typedef struct packed {
    logic              help_request;
    logic              command_valid;
    logic              valid_led_on;
    logic              rx_led_on;
    logic [EVT_W-1:0]  pending_events;
    logic [HELD_W-1:0] held_buttons;
  } rbcd_res_t;

endpackage

// ===== rtl/remote_button_command_decoder_top.sv =====
// ----------------------------------------------------------------------------
// remote_button_command_decoder_top
// Turns received serial command bytes, millisecond ticks, take and clear
// requests into held button states and latched press events. A request is
// one of: received byte (one-byte command, or part of a three-byte packet
// '!', code, '0'/'1'), tick (ages tap timers and led timers, ends rotate),
// take (reports the pending events and clears those selected by the mask)
// and clear (returns all state to reset, configuration kept). Every request
// gives exactly one result. The block takes one request per clock cycle
// while the result channel is not stalled; a request passes through the
// input register and then the result register, where its result is held
// until taken, and the decoder state is updated as it moves between them,
// so back-to-back requests see each other's effects. Configuration
// (register 0 tap length, register 1 led hold time, both in ticks) is
// written through the cfg port, which is always ready; write it only while
// no request is in flight.
// ----------------------------------------------------------------------------
`include "remote_button_command_decoder_top_assert.svh"

module remote_button_command_decoder_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [7:0] rx_byte, [25:8] take_mask, [31:26] zero
  input  logic [rbcd_pkg::IN_TDATA_W-1:0]       in_tdata,
  // [1:0] cmd
  input  logic [rbcd_pkg::IN_TUSER_W-1:0]       in_tuser,
  // result channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [10:0] held_buttons, [28:11] pending_events, [29] rx_led_on,
  // [30] valid_led_on, [31] command_valid, [32] help_request, [39:33] zero
  output logic [rbcd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_index,
  input  logic [rbcd_pkg::CNT_W-1:0]            cfg_data
);

  localparam int RES_W = $bits(rbcd_pkg::rbcd_res_t);

  rbcd_pkg::rbcd_cfg_t   cfg;
  rbcd_pkg::rbcd_state_t st_r;
  rbcd_pkg::rbcd_state_t st_nxt;
  rbcd_pkg::rbcd_item_t  item_r;
  rbcd_pkg::rbcd_res_t   res;
  rbcd_pkg::rbcd_res_t   res_r;

  logic s1_valid_r;
  logic out_valid_r;
  logic out_adv;
  logic s1_fire;
  logic in_fire;

  // configuration registers
  rbcd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // decode logic between the input register and the result register
  rbcd_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // result register frees when empty or being taken; input register follows
  assign out_adv   = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_adv;
  assign in_tready = !s1_valid_r || out_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_tready) s1_valid_r  <= in_tvalid;
      if (out_adv)   out_valid_r <= s1_valid_r;
      // decoder state commits as the request moves into the result register
      if (s1_fire)   st_r        <= st_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.cmd       <= rbcd_pkg::cmd_t'(in_tuser[1:0]);
      item_r.rx_byte   <= in_tdata[7:0];
      item_r.take_mask <= in_tdata[25:8];
    end
    if (s1_fire) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(rbcd_pkg::OUT_TDATA_W - RES_W){1'b0}}, res_r};

  // a request leaving the input register always lands in the result register
  `RBCD_ASSERT_NXT(a_s1_to_out, s1_fire, out_valid_r, "result register missed a request")
  // help is itself a recognised command
  `RBCD_ASSERT_IMP(a_help_valid, out_valid_r && res_r.help_request, res_r.command_valid,
                   "help flagged without command valid")
  // a pending tap always has its button held
  `RBCD_ASSERT_IMP(a_tap_a_held, st_r.a_pend, st_r.held[rbcd_pkg::H_A],
                   "tap on A pending with A released")
  `RBCD_ASSERT_IMP(a_tap_b_held, st_r.b_pend, st_r.held[rbcd_pkg::H_B],
                   "tap on B pending with B released")

endmodule

// ===== rtl/rbcd_cfg.sv =====
// ----------------------------------------------------------------------------
// rbcd_cfg
// configuration registers: tap length and activity led hold time
// ----------------------------------------------------------------------------
module rbcd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [rbcd_pkg::CNT_W-1:0]       cfg_data,
  output rbcd_pkg::rbcd_cfg_t              cfg
);

  logic [rbcd_pkg::CNT_W-1:0] tap_r;
  logic [rbcd_pkg::CNT_W-1:0] led_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= rbcd_pkg::TAP_RESET;
      led_r <= rbcd_pkg::LED_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rbcd_pkg::REG_TAP: tap_r <= cfg_data;
        rbcd_pkg::REG_LED: led_r <= cfg_data;
      endcase
    end
  end

  assign cfg.tap_ticks      = tap_r;
  assign cfg.led_hold_ticks = led_r;

endmodule

// ===== rtl/rbcd_step.sv =====
// ----------------------------------------------------------------------------
// rbcd_step
// next-state and result logic for one request
// ----------------------------------------------------------------------------
module rbcd_step (
  input  rbcd_pkg::rbcd_cfg_t   cfg,
  input  rbcd_pkg::rbcd_state_t st,
  input  rbcd_pkg::rbcd_item_t  item,
  output rbcd_pkg::rbcd_state_t st_nxt,
  output rbcd_pkg::rbcd_res_t   res
);

  typedef struct packed {
    logic [rbcd_pkg::HELD_W-1:0] held;
    logic [rbcd_pkg::EVT_W-1:0]  evt;
  } btn_t;

  // press or release one button, logging an event on a fresh press
  function automatic btn_t set_btn(btn_t b, rbcd_pkg::hbit_t hb, rbcd_pkg::ebit_t eb,
                                   logic on);
    btn_t r;
    r = b;
    if (on && !b.held[hb]) r.evt[eb] = 1'b1;
    r.held[hb] = on;
    return r;
  endfunction

  rbcd_pkg::rbcd_state_t nx;
  btn_t                  bt;
  logic                  valid;
  logic                  help;
  logic                  pkt_on;

  assign pkt_on = (item.rx_byte == rbcd_pkg::CH_1);

  always_comb begin
    nx       = st;
    bt.held  = st.held;
    bt.evt   = st.evt;
    valid    = 1'b0;
    help     = 1'b0;
    unique case (item.cmd)
      rbcd_pkg::CMD_BYTE: begin
        nx.rx_cnt = cfg.led_hold_ticks;
        if (st.phase == rbcd_pkg::PH_IDLE) begin
          if (item.rx_byte == rbcd_pkg::CH_BANG) begin
            nx.phase = rbcd_pkg::PH_CODE;
          end else begin
            valid = 1'b1;
            unique case (item.rx_byte)
              rbcd_pkg::CH_U: bt.evt[rbcd_pkg::E_MUP] = 1'b1;
              rbcd_pkg::CH_D: bt.evt[rbcd_pkg::E_MDN] = 1'b1;
              rbcd_pkg::CH_E: bt.evt[rbcd_pkg::E_MENT] = 1'b1;
              rbcd_pkg::CH_A: begin
                bt = set_btn(bt, rbcd_pkg::H_A, rbcd_pkg::E_A, 1'b1);
                nx.a_pend = 1'b0;
              end
              rbcd_pkg::CH_A_LC: begin
                bt.held[rbcd_pkg::H_A] = 1'b0;
                nx.a_pend = 1'b0;
              end
              rbcd_pkg::CH_B: begin
                bt = set_btn(bt, rbcd_pkg::H_B, rbcd_pkg::E_B, 1'b1);
                nx.b_pend = 1'b0;
              end
              rbcd_pkg::CH_B_LC: begin
                bt.held[rbcd_pkg::H_B] = 1'b0;
                nx.b_pend = 1'b0;
              end
              rbcd_pkg::CH_L: begin
                bt = set_btn(bt, rbcd_pkg::H_A, rbcd_pkg::E_A, 1'b1);
                nx.a_pend = 1'b1;
                nx.a_cnt  = cfg.tap_ticks;
              end
              rbcd_pkg::CH_R: begin
                bt = set_btn(bt, rbcd_pkg::H_B, rbcd_pkg::E_B, 1'b1);
                nx.b_pend = 1'b1;
                nx.b_cnt  = cfg.tap_ticks;
              end
              rbcd_pkg::CH_T, rbcd_pkg::CH_7: begin
                bt.evt[rbcd_pkg::E_ROT]  = 1'b1;
                bt.held[rbcd_pkg::H_ROT] = 1'b1;
              end
              rbcd_pkg::CH_X, rbcd_pkg::CH_X_LC: bt.evt[rbcd_pkg::E_EXIT] = 1'b1;
              rbcd_pkg::CH_S: begin
                bt.held = '0;
                nx.a_pend = 1'b0;
                nx.b_pend = 1'b0;
              end
              rbcd_pkg::CH_S_LC: begin
                // p2 buttons stay held
                bt.held = bt.held & rbcd_pkg::HM_P2;
                nx.a_pend = 1'b0;
                nx.b_pend = 1'b0;
              end
              rbcd_pkg::CH_QUERY: help = 1'b1;
              rbcd_pkg::CH_1: bt = set_btn(bt, rbcd_pkg::H_UP, rbcd_pkg::E_UP, 1'b1);
              rbcd_pkg::CH_Q_LC: bt = set_btn(bt, rbcd_pkg::H_UP, rbcd_pkg::E_UP, 1'b0);
              rbcd_pkg::CH_2: bt = set_btn(bt, rbcd_pkg::H_DOWN, rbcd_pkg::E_DOWN, 1'b1);
              rbcd_pkg::CH_W_LC: bt = set_btn(bt, rbcd_pkg::H_DOWN, rbcd_pkg::E_DOWN, 1'b0);
              rbcd_pkg::CH_3: bt = set_btn(bt, rbcd_pkg::H_LEFT, rbcd_pkg::E_LEFT, 1'b1);
              rbcd_pkg::CH_E_LC: bt = set_btn(bt, rbcd_pkg::H_LEFT, rbcd_pkg::E_LEFT, 1'b0);
              rbcd_pkg::CH_4: bt = set_btn(bt, rbcd_pkg::H_RIGHT, rbcd_pkg::E_RIGHT, 1'b1);
              rbcd_pkg::CH_R_LC: bt = set_btn(bt, rbcd_pkg::H_RIGHT, rbcd_pkg::E_RIGHT, 1'b0);
              rbcd_pkg::CH_5: bt = set_btn(bt, rbcd_pkg::H_ACT1, rbcd_pkg::E_ACT1, 1'b1);
              rbcd_pkg::CH_T_LC: bt = set_btn(bt, rbcd_pkg::H_ACT1, rbcd_pkg::E_ACT1, 1'b0);
              rbcd_pkg::CH_6: bt = set_btn(bt, rbcd_pkg::H_ACT2, rbcd_pkg::E_ACT2, 1'b1);
              rbcd_pkg::CH_Y_LC: bt = set_btn(bt, rbcd_pkg::H_ACT2, rbcd_pkg::E_ACT2, 1'b0);
              rbcd_pkg::CH_8: bt.evt[rbcd_pkg::E_DROP]  = 1'b1;
              rbcd_pkg::CH_9: bt.evt[rbcd_pkg::E_PAUSE] = 1'b1;
              rbcd_pkg::CH_0: bt.evt[rbcd_pkg::E_START] = 1'b1;
              rbcd_pkg::CH_I: bt = set_btn(bt, rbcd_pkg::H_P2UP, rbcd_pkg::E_P2UP, 1'b1);
              rbcd_pkg::CH_I_LC: bt = set_btn(bt, rbcd_pkg::H_P2UP, rbcd_pkg::E_P2UP, 1'b0);
              rbcd_pkg::CH_K: bt = set_btn(bt, rbcd_pkg::H_P2DN, rbcd_pkg::E_P2DN, 1'b1);
              rbcd_pkg::CH_K_LC: bt = set_btn(bt, rbcd_pkg::H_P2DN, rbcd_pkg::E_P2DN, 1'b0);
              rbcd_pkg::CH_Z_LC: bt.held = bt.held & ~rbcd_pkg::HM_P2;
              default: valid = 1'b0;
            endcase
          end
        end else if (st.phase == rbcd_pkg::PH_CODE) begin
          nx.code  = item.rx_byte;
          nx.phase = rbcd_pkg::PH_DATA;
        end else begin
          // value byte: only '0' or '1' completes a valid packet
          valid    = pkt_on || (item.rx_byte == rbcd_pkg::CH_0);
          nx.phase = rbcd_pkg::PH_IDLE;
          unique case (st.code)
            rbcd_pkg::CH_U: bt = set_btn(bt, rbcd_pkg::H_UP, rbcd_pkg::E_UP, pkt_on);
            rbcd_pkg::CH_D: bt = set_btn(bt, rbcd_pkg::H_DOWN, rbcd_pkg::E_DOWN, pkt_on);
            rbcd_pkg::CH_L: bt = set_btn(bt, rbcd_pkg::H_LEFT, rbcd_pkg::E_LEFT, pkt_on);
            rbcd_pkg::CH_R: bt = set_btn(bt, rbcd_pkg::H_RIGHT, rbcd_pkg::E_RIGHT, pkt_on);
            rbcd_pkg::CH_A: bt = set_btn(bt, rbcd_pkg::H_ACT1, rbcd_pkg::E_ACT1, pkt_on);
            rbcd_pkg::CH_B: bt = set_btn(bt, rbcd_pkg::H_ACT2, rbcd_pkg::E_ACT2, pkt_on);
            rbcd_pkg::CH_T: begin
              if (pkt_on) begin
                bt.evt[rbcd_pkg::E_ROT]  = 1'b1;
                bt.held[rbcd_pkg::H_ROT] = 1'b1;
              end
            end
            rbcd_pkg::CH_H: if (pkt_on) bt.evt[rbcd_pkg::E_DROP]  = 1'b1;
            rbcd_pkg::CH_P: if (pkt_on) bt.evt[rbcd_pkg::E_PAUSE] = 1'b1;
            rbcd_pkg::CH_E: if (pkt_on) bt.evt[rbcd_pkg::E_START] = 1'b1;
            rbcd_pkg::CH_X: if (pkt_on) bt.evt[rbcd_pkg::E_EXIT]  = 1'b1;
            rbcd_pkg::CH_S: begin
              // rotate stays held
              if (pkt_on) begin
                bt.held   = bt.held & rbcd_pkg::HM_ROT;
                nx.a_pend = 1'b0;
                nx.b_pend = 1'b0;
              end
            end
            default: valid = 1'b0;
          endcase
        end
        if (valid) nx.vld_cnt = cfg.led_hold_ticks;
      end
      rbcd_pkg::CMD_TICK: begin
        if (st.rx_cnt != '0)  nx.rx_cnt  = st.rx_cnt - 10'd1;
        if (st.vld_cnt != '0) nx.vld_cnt = st.vld_cnt - 10'd1;
        if (st.a_pend) begin
          if (st.a_cnt != '0) nx.a_cnt = st.a_cnt - 10'd1;
          if (st.a_cnt <= 10'd1) begin
            bt.held[rbcd_pkg::H_A] = 1'b0;
            nx.a_pend = 1'b0;
          end
        end
        if (st.b_pend) begin
          if (st.b_cnt != '0) nx.b_cnt = st.b_cnt - 10'd1;
          if (st.b_cnt <= 10'd1) begin
            bt.held[rbcd_pkg::H_B] = 1'b0;
            nx.b_pend = 1'b0;
          end
        end
        bt.held[rbcd_pkg::H_ROT] = 1'b0;
      end
      rbcd_pkg::CMD_TAKE: bt.evt = st.evt & ~item.take_mask;
      rbcd_pkg::CMD_CLEAR: begin
        nx = '0;
        bt = '0;
      end
    endcase
    nx.held = bt.held;
    nx.evt  = bt.evt;
  end

  assign st_nxt = nx;

  assign res.held_buttons   = nx.held;
  // take reports the events as they stood before clearing
  assign res.pending_events = (item.cmd == rbcd_pkg::CMD_TAKE) ? st.evt : nx.evt;
  assign res.rx_led_on      = (nx.rx_cnt != '0);
  assign res.valid_led_on   = (nx.vld_cnt != '0);
  assign res.command_valid  = valid;
  assign res.help_request   = help;

endmodule

// ===== bench/remote_button_command_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// remote_button_command_decoder_top_tb
// Self-checking bench for the remote button command decoder. A queue of
// requests (bytes, ticks, takes, clears) feeds a clocked driver; a clocked
// monitor compares every result, field by field, against a bit-true
// prediction of held buttons, latched events, led state and flags. Tap and
// led lengths are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module remote_button_command_decoder_top_tb;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned HOLD_OFF_CYCLES = 250;
  localparam int unsigned TAIL_CYCLES     = 8;

  localparam rbcd_pkg::chr_t SINGLE_CMDS [36] = '{
    rbcd_pkg::CH_U, rbcd_pkg::CH_D, rbcd_pkg::CH_E, rbcd_pkg::CH_A, rbcd_pkg::CH_A_LC,
    rbcd_pkg::CH_B, rbcd_pkg::CH_B_LC, rbcd_pkg::CH_L, rbcd_pkg::CH_R, rbcd_pkg::CH_T,
    rbcd_pkg::CH_7, rbcd_pkg::CH_X, rbcd_pkg::CH_X_LC, rbcd_pkg::CH_S, rbcd_pkg::CH_S_LC,
    rbcd_pkg::CH_QUERY, rbcd_pkg::CH_1, rbcd_pkg::CH_Q_LC, rbcd_pkg::CH_2,
    rbcd_pkg::CH_W_LC, rbcd_pkg::CH_3, rbcd_pkg::CH_E_LC, rbcd_pkg::CH_4,
    rbcd_pkg::CH_R_LC, rbcd_pkg::CH_5, rbcd_pkg::CH_T_LC, rbcd_pkg::CH_6,
    rbcd_pkg::CH_Y_LC, rbcd_pkg::CH_8, rbcd_pkg::CH_9, rbcd_pkg::CH_0, rbcd_pkg::CH_I,
    rbcd_pkg::CH_I_LC, rbcd_pkg::CH_K, rbcd_pkg::CH_K_LC, rbcd_pkg::CH_Z_LC
  };
  localparam rbcd_pkg::chr_t PACKET_CODES [12] = '{
    rbcd_pkg::CH_U, rbcd_pkg::CH_D, rbcd_pkg::CH_L, rbcd_pkg::CH_R, rbcd_pkg::CH_A,
    rbcd_pkg::CH_B, rbcd_pkg::CH_T, rbcd_pkg::CH_H, rbcd_pkg::CH_P, rbcd_pkg::CH_E,
    rbcd_pkg::CH_X, rbcd_pkg::CH_S
  };

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [rbcd_pkg::IN_TDATA_W-1:0]   in_tdata = '0;
  logic [rbcd_pkg::IN_TUSER_W-1:0]   in_tuser = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [rbcd_pkg::OUT_TDATA_W-1:0]  out_tdata;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic                              cfg_index = 1'b0;
  logic [rbcd_pkg::CNT_W-1:0]        cfg_data = '0;

  remote_button_command_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // decoder shadow: state and register copies used for prediction
  // ---------------------------------------------------------------------------
  rbcd_pkg::rbcd_state_t      dec_st = '0;
  logic [rbcd_pkg::CNT_W-1:0] tap_len = rbcd_pkg::TAP_RESET;
  logic [rbcd_pkg::CNT_W-1:0] led_len = rbcd_pkg::LED_RESET;

  rbcd_pkg::rbcd_item_t request_q [$];      // requests waiting for the driver
  rbcd_pkg::rbcd_res_t  report_q [$];       // predicted results, oldest first
  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned mismatch_cnt = 0;

  // idling controls, changed per phase
  logic gap_free   = 1'b0;
  logic stall_free = 1'b0;
  logic pressure_go = 1'b0;
  logic hold_off    = 1'b0;

  task automatic note_mismatch(string msg);
    $display("mismatch at result %0d: %s", checked_cnt, msg);
    mismatch_cnt++;
  endtask

  // a press only latches an event on the released-to-held transition
  function automatic void set_button(rbcd_pkg::hbit_t hb, rbcd_pkg::ebit_t eb, logic on);
    if (on && !dec_st.held[hb]) dec_st.evt[eb] = 1'b1;
    dec_st.held[hb] = on;
  endfunction

  function automatic void release_taps();
    dec_st.held[rbcd_pkg::H_A] = 1'b0;
    dec_st.held[rbcd_pkg::H_B] = 1'b0;
    dec_st.a_pend = 1'b0;
    dec_st.b_pend = 1'b0;
  endfunction

  function automatic void rotate_tap();
    dec_st.evt[rbcd_pkg::E_ROT] = 1'b1;
    dec_st.held[rbcd_pkg::H_ROT] = 1'b1;
  endfunction

  function automatic logic single_byte_cmd(rbcd_pkg::chr_t c, output logic help);
    logic known;
    known = 1'b1;
    help = 1'b0;
    case (c)
      rbcd_pkg::CH_U:     dec_st.evt[rbcd_pkg::E_MUP] = 1'b1;
      rbcd_pkg::CH_D:     dec_st.evt[rbcd_pkg::E_MDN] = 1'b1;
      rbcd_pkg::CH_E:     dec_st.evt[rbcd_pkg::E_MENT] = 1'b1;
      rbcd_pkg::CH_A: begin
        set_button(rbcd_pkg::H_A, rbcd_pkg::E_A, 1'b1);
        dec_st.a_pend = 1'b0;
      end
      rbcd_pkg::CH_A_LC: begin
        dec_st.held[rbcd_pkg::H_A] = 1'b0;
        dec_st.a_pend = 1'b0;
      end
      rbcd_pkg::CH_B: begin
        set_button(rbcd_pkg::H_B, rbcd_pkg::E_B, 1'b1);
        dec_st.b_pend = 1'b0;
      end
      rbcd_pkg::CH_B_LC: begin
        dec_st.held[rbcd_pkg::H_B] = 1'b0;
        dec_st.b_pend = 1'b0;
      end
      rbcd_pkg::CH_L: begin
        set_button(rbcd_pkg::H_A, rbcd_pkg::E_A, 1'b1);
        dec_st.a_pend = 1'b1;
        dec_st.a_cnt = tap_len;
      end
      rbcd_pkg::CH_R: begin
        set_button(rbcd_pkg::H_B, rbcd_pkg::E_B, 1'b1);
        dec_st.b_pend = 1'b1;
        dec_st.b_cnt = tap_len;
      end
      rbcd_pkg::CH_T, rbcd_pkg::CH_7:     rotate_tap();
      rbcd_pkg::CH_X, rbcd_pkg::CH_X_LC:  dec_st.evt[rbcd_pkg::E_EXIT] = 1'b1;
      rbcd_pkg::CH_S: begin
        release_taps();
        dec_st.held = dec_st.held & ~(rbcd_pkg::HM_ROT | rbcd_pkg::HM_EXT | rbcd_pkg::HM_P2);
      end
      rbcd_pkg::CH_S_LC: begin
        release_taps();
        dec_st.held = dec_st.held & ~(rbcd_pkg::HM_ROT | rbcd_pkg::HM_EXT);
      end
      rbcd_pkg::CH_QUERY: help = 1'b1;
      rbcd_pkg::CH_1:     set_button(rbcd_pkg::H_UP, rbcd_pkg::E_UP, 1'b1);
      rbcd_pkg::CH_Q_LC:  set_button(rbcd_pkg::H_UP, rbcd_pkg::E_UP, 1'b0);
      rbcd_pkg::CH_2:     set_button(rbcd_pkg::H_DOWN, rbcd_pkg::E_DOWN, 1'b1);
      rbcd_pkg::CH_W_LC:  set_button(rbcd_pkg::H_DOWN, rbcd_pkg::E_DOWN, 1'b0);
      rbcd_pkg::CH_3:     set_button(rbcd_pkg::H_LEFT, rbcd_pkg::E_LEFT, 1'b1);
      rbcd_pkg::CH_E_LC:  set_button(rbcd_pkg::H_LEFT, rbcd_pkg::E_LEFT, 1'b0);
      rbcd_pkg::CH_4:     set_button(rbcd_pkg::H_RIGHT, rbcd_pkg::E_RIGHT, 1'b1);
      rbcd_pkg::CH_R_LC:  set_button(rbcd_pkg::H_RIGHT, rbcd_pkg::E_RIGHT, 1'b0);
      rbcd_pkg::CH_5:     set_button(rbcd_pkg::H_ACT1, rbcd_pkg::E_ACT1, 1'b1);
      rbcd_pkg::CH_T_LC:  set_button(rbcd_pkg::H_ACT1, rbcd_pkg::E_ACT1, 1'b0);
      rbcd_pkg::CH_6:     set_button(rbcd_pkg::H_ACT2, rbcd_pkg::E_ACT2, 1'b1);
      rbcd_pkg::CH_Y_LC:  set_button(rbcd_pkg::H_ACT2, rbcd_pkg::E_ACT2, 1'b0);
      rbcd_pkg::CH_8:     dec_st.evt[rbcd_pkg::E_DROP] = 1'b1;
      rbcd_pkg::CH_9:     dec_st.evt[rbcd_pkg::E_PAUSE] = 1'b1;
      rbcd_pkg::CH_0:     dec_st.evt[rbcd_pkg::E_START] = 1'b1;
      rbcd_pkg::CH_I:     set_button(rbcd_pkg::H_P2UP, rbcd_pkg::E_P2UP, 1'b1);
      rbcd_pkg::CH_I_LC:  set_button(rbcd_pkg::H_P2UP, rbcd_pkg::E_P2UP, 1'b0);
      rbcd_pkg::CH_K:     set_button(rbcd_pkg::H_P2DN, rbcd_pkg::E_P2DN, 1'b1);
      rbcd_pkg::CH_K_LC:  set_button(rbcd_pkg::H_P2DN, rbcd_pkg::E_P2DN, 1'b0);
      rbcd_pkg::CH_Z_LC:  dec_st.held = dec_st.held & ~rbcd_pkg::HM_P2;
      default:            known = 1'b0;
    endcase
    return known;
  endfunction

  // a button code with a value other than '1' still releases its held button
  function automatic logic packet_cmd(rbcd_pkg::chr_t code, rbcd_pkg::chr_t value);
    logic on;
    logic ok;
    on = (value == rbcd_pkg::CH_1);
    ok = on || (value == rbcd_pkg::CH_0);
    case (code)
      rbcd_pkg::CH_U: set_button(rbcd_pkg::H_UP, rbcd_pkg::E_UP, on);
      rbcd_pkg::CH_D: set_button(rbcd_pkg::H_DOWN, rbcd_pkg::E_DOWN, on);
      rbcd_pkg::CH_L: set_button(rbcd_pkg::H_LEFT, rbcd_pkg::E_LEFT, on);
      rbcd_pkg::CH_R: set_button(rbcd_pkg::H_RIGHT, rbcd_pkg::E_RIGHT, on);
      rbcd_pkg::CH_A: set_button(rbcd_pkg::H_ACT1, rbcd_pkg::E_ACT1, on);
      rbcd_pkg::CH_B: set_button(rbcd_pkg::H_ACT2, rbcd_pkg::E_ACT2, on);
      rbcd_pkg::CH_T: if (on) rotate_tap();
      rbcd_pkg::CH_H: if (on) dec_st.evt[rbcd_pkg::E_DROP] = 1'b1;
      rbcd_pkg::CH_P: if (on) dec_st.evt[rbcd_pkg::E_PAUSE] = 1'b1;
      rbcd_pkg::CH_E: if (on) dec_st.evt[rbcd_pkg::E_START] = 1'b1;
      rbcd_pkg::CH_X: if (on) dec_st.evt[rbcd_pkg::E_EXIT] = 1'b1;
      rbcd_pkg::CH_S: if (on) begin
        // rotate survives the packet stop
        release_taps();
        dec_st.held = dec_st.held & ~(rbcd_pkg::HM_EXT | rbcd_pkg::HM_P2);
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic rbcd_pkg::rbcd_res_t predict_button_report(rbcd_pkg::rbcd_item_t it);
    rbcd_pkg::rbcd_res_t        r;
    logic                       vld;
    logic                       hlp;
    logic [rbcd_pkg::EVT_W-1:0] snap;
    vld = 1'b0;
    hlp = 1'b0;
    case (it.cmd)
      rbcd_pkg::CMD_BYTE: begin
        dec_st.rx_cnt = led_len;
        if (dec_st.phase == rbcd_pkg::PH_IDLE) begin
          if (it.rx_byte == rbcd_pkg::CH_BANG) dec_st.phase = rbcd_pkg::PH_CODE;
          else vld = single_byte_cmd(it.rx_byte, hlp);
        end else if (dec_st.phase == rbcd_pkg::PH_CODE) begin
          dec_st.code = it.rx_byte;
          dec_st.phase = rbcd_pkg::PH_DATA;
        end else begin
          vld = packet_cmd(dec_st.code, it.rx_byte);
          dec_st.phase = rbcd_pkg::PH_IDLE;
        end
        if (vld) dec_st.vld_cnt = led_len;
        snap = dec_st.evt;
      end
      rbcd_pkg::CMD_TICK: begin
        if (dec_st.rx_cnt != '0) dec_st.rx_cnt = dec_st.rx_cnt - 10'd1;
        if (dec_st.vld_cnt != '0) dec_st.vld_cnt = dec_st.vld_cnt - 10'd1;
        if (dec_st.a_pend) begin
          if (dec_st.a_cnt != '0) dec_st.a_cnt = dec_st.a_cnt - 10'd1;
          if (dec_st.a_cnt == '0) begin
            dec_st.held[rbcd_pkg::H_A] = 1'b0;
            dec_st.a_pend = 1'b0;
          end
        end
        if (dec_st.b_pend) begin
          if (dec_st.b_cnt != '0) dec_st.b_cnt = dec_st.b_cnt - 10'd1;
          if (dec_st.b_cnt == '0) begin
            dec_st.held[rbcd_pkg::H_B] = 1'b0;
            dec_st.b_pend = 1'b0;
          end
        end
        dec_st.held[rbcd_pkg::H_ROT] = 1'b0;
        snap = dec_st.evt;
      end
      rbcd_pkg::CMD_TAKE: begin
        // reported before the selected bits are cleared
        snap = dec_st.evt;
        dec_st.evt = dec_st.evt & ~it.take_mask;
      end
      default: begin
        dec_st = '0;
        snap = dec_st.evt;
      end
    endcase
    r.held_buttons   = dec_st.held;
    r.pending_events = snap;
    r.rx_led_on      = (dec_st.rx_cnt != '0);
    r.valid_led_on   = (dec_st.vld_cnt != '0);
    r.command_valid  = vld;
    r.help_request   = hlp;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: one request in flight on the input channel at a time
  // ---------------------------------------------------------------------------
  rbcd_pkg::rbcd_item_t drive_item;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        report_q.push_back(predict_button_report(drive_item));
        accepted_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (request_q.size() != 0) begin
          drive_item = request_q.pop_front();
          // tdata: rx_byte low, take_mask above, zero fill
          in_tdata  <= {6'd0, drive_item.take_mask, drive_item.rx_byte};
          in_tuser  <= drive_item.cmd;
          in_tvalid <= 1'b1;
          gap_left = gap_free ? 0 : $urandom_range(0, 9);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver back-pressure
  // ---------------------------------------------------------------------------
  rbcd_pkg::rbcd_res_t mon_got;
  rbcd_pkg::rbcd_res_t mon_want;
  int unsigned stall_left = 0;

  task automatic compare_field(string name, logic [31:0] got_v, logic [31:0] want_v);
    if (got_v != want_v)
      note_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got_v, want_v));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        mon_got = out_tdata[32:0];
        if (report_q.size() == 0) begin
          note_mismatch("result with no request waiting");
        end else begin
          mon_want = report_q.pop_front();
          if ($isunknown(out_tdata[32:0])) note_mismatch("unknown bits in result");
          compare_field("held_buttons", 32'(mon_got.held_buttons),
                        32'(mon_want.held_buttons));
          compare_field("pending_events", 32'(mon_got.pending_events),
                        32'(mon_want.pending_events));
          compare_field("rx_led_on", 32'(mon_got.rx_led_on), 32'(mon_want.rx_led_on));
          compare_field("valid_led_on", 32'(mon_got.valid_led_on),
                        32'(mon_want.valid_led_on));
          compare_field("command_valid", 32'(mon_got.command_valid),
                        32'(mon_want.command_valid));
          compare_field("help_request", 32'(mon_got.help_request),
                        32'(mon_want.help_request));
        end
        checked_cnt++;
        stall_left = stall_free ? 0 : $urandom_range(0, 9);
      end
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("remote_button_command_decoder_top test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [rbcd_pkg::EVT_W-1:0] rand_mask();
    logic [31:0] rnd;
    rnd = $urandom();
    return rnd[rbcd_pkg::EVT_W-1:0];
  endfunction

  function automatic rbcd_pkg::chr_t rand_byte();
    logic [31:0] rnd;
    rnd = $urandom();
    return rnd[rbcd_pkg::BYTE_W-1:0];
  endfunction

  // unused fields carry noise so the block must ignore them
  task automatic queue_req(rbcd_pkg::cmd_t c, rbcd_pkg::chr_t b,
                           logic [rbcd_pkg::EVT_W-1:0] m);
    rbcd_pkg::rbcd_item_t it;
    it.cmd = c;
    it.rx_byte = b;
    it.take_mask = m;
    request_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic send_byte(rbcd_pkg::chr_t b);
    queue_req(rbcd_pkg::CMD_BYTE, b, rand_mask());
  endtask

  task automatic send_tick();
    queue_req(rbcd_pkg::CMD_TICK, rand_byte(), rand_mask());
  endtask

  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || checked_cnt != queued_cnt) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [rbcd_pkg::CNT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == rbcd_pkg::REG_TAP) tap_len = val;
    else led_len = val;
  endtask

  task automatic set_lengths(logic [rbcd_pkg::CNT_W-1:0] tap_v,
                             logic [rbcd_pkg::CNT_W-1:0] led_v);
    wait_idle();
    write_reg(rbcd_pkg::REG_TAP, tap_v);
    write_reg(rbcd_pkg::REG_LED, led_v);
  endtask

  // mostly well-formed commands and packets, the rest noise and broken packets
  task automatic queue_random_traffic(int unsigned n);
    int unsigned base;
    int unsigned pick;
    int unsigned k;
    logic [rbcd_pkg::EVT_W-1:0] m;
    base = queued_cnt;
    while (queued_cnt - base < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_byte(SINGLE_CMDS[$urandom_range(0, 35)]);
      end else if (pick < 55) begin
        send_byte(rbcd_pkg::CH_BANG);
        send_byte(($urandom_range(0, 9) != 0) ? PACKET_CODES[$urandom_range(0, 11)]
                                              : rand_byte());
        k = $urandom_range(0, 9);
        send_byte((k < 5) ? rbcd_pkg::CH_1 : (k < 8) ? rbcd_pkg::CH_0 : rand_byte());
      end else if (pick < 73) begin
        k = $urandom_range(1, 4);
        repeat (k) send_tick();
      end else if (pick < 81) begin
        m = ($urandom_range(0, 3) == 0) ? {rbcd_pkg::EVT_W{1'b1}} : rand_mask();
        queue_req(rbcd_pkg::CMD_TAKE, rand_byte(), m);
      end else if (pick < 83) begin
        queue_req(rbcd_pkg::CMD_CLEAR, rand_byte(), rand_mask());
      end else if (pick < 93) begin
        send_byte(rand_byte());
      end else begin
        // packet cut short: a new start lands as code or value
        send_byte(rbcd_pkg::CH_BANG);
        if ($urandom_range(0, 1) != 0) send_byte(PACKET_CODES[$urandom_range(0, 11)]);
        send_byte(rbcd_pkg::CH_BANG);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset lengths, directed requests
    send_byte(rbcd_pkg::CH_QUERY);
    send_byte(rbcd_pkg::CH_L);
    send_byte(rbcd_pkg::CH_R);
    send_byte(rbcd_pkg::CH_T);
    send_byte(rbcd_pkg::CH_I);
    // packet stop keeps rotate held
    send_byte(rbcd_pkg::CH_BANG);
    send_byte(rbcd_pkg::CH_S);
    send_byte(rbcd_pkg::CH_1);
    send_byte(rbcd_pkg::CH_S_LC);
    send_byte(rbcd_pkg::CH_K);
    send_byte(rbcd_pkg::CH_Z_LC);
    // start byte inside a packet is data
    send_byte(rbcd_pkg::CH_BANG);
    send_byte(rbcd_pkg::CH_BANG);
    send_byte(rbcd_pkg::CH_1);
    // known code, bad value
    send_byte(rbcd_pkg::CH_BANG);
    send_byte(rbcd_pkg::CH_U);
    send_byte(rbcd_pkg::CH_2);
    // unknown bytes
    send_byte(8'hFF);
    send_byte(8'h00);
    send_tick();
    queue_req(rbcd_pkg::CMD_TAKE, 8'hFF, {rbcd_pkg::EVT_W{1'b1}});
    queue_req(rbcd_pkg::CMD_TAKE, 8'h00, '0);
    queue_req(rbcd_pkg::CMD_CLEAR, 8'hFF, {rbcd_pkg::EVT_W{1'b1}});

    // zero lengths: leds stay dark, a tap ends on the next tick
    set_lengths('0, '0);
    send_byte(rbcd_pkg::CH_L);
    send_tick();
    send_byte(rbcd_pkg::CH_5);
    send_tick();
    queue_random_traffic(90);

    // shortest non-zero lengths, no idling on either side
    set_lengths(10'd1, 10'd1);
    gap_free = 1'b1;
    stall_free = 1'b1;
    queue_random_traffic(200);

    // longest lengths under receiver hold-off
    set_lengths({rbcd_pkg::CNT_W{1'b1}}, {rbcd_pkg::CNT_W{1'b1}});
    stall_free = 1'b0;
    pressure_go = 1'b1;
    queue_random_traffic(150);

    // small random lengths, random idling
    set_lengths(rbcd_pkg::CNT_W'($urandom_range(1, 6)),
                rbcd_pkg::CNT_W'($urandom_range(1, 6)));
    gap_free = 1'b0;
    queue_random_traffic(200);

    set_lengths(10'd2, {rbcd_pkg::CNT_W{1'b1}});
    stall_free = 1'b1;
    queue_random_traffic(170);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (report_q.size() != 0) note_mismatch("predicted results never arrived");
    if (mismatch_cnt == 0) begin
      $display("remote_button_command_decoder_top test passed");
    end else begin
      $display("remote_button_command_decoder_top test failed");
    end
    $finish;
  end

endmodule
